FILE: hw/rtl/osm_pkg.sv
// ----------------------------------------------------------------------------
// osm_pkg
// Shared types and constants of the order slot state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package osm_pkg;

  localparam int INST_COUNT = 16;
  localparam int ROW_W      = (INST_COUNT > 1) ? $clog2(INST_COUNT) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] OFFSET_OPEN = 3'd0;
  localparam logic [2:0] OFFSET_BAD  = 3'd7;

  typedef enum logic [1:0] {
    OP_RESPONSE = 2'd0,
    OP_QUOTE    = 2'd1,
    OP_CLOSE    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    RESP_ACCEPTED        = 3'd0,
    RESP_FILLED          = 3'd1,
    RESP_CANCELED        = 3'd2,
    RESP_REJECTED        = 3'd3,
    RESP_CANCEL_REJECTED = 3'd4,
    RESP_INVALID         = 3'd5
  } resp_t;

  typedef enum logic [2:0] {
    ST_INVALID        = 3'd0,
    ST_PENDING_NEW    = 3'd1,
    ST_LIVE           = 3'd2,
    ST_PENDING_CANCEL = 3'd3,
    ST_DEAD           = 3'd4
  } slot_st_t;

  typedef enum logic {
    REQ_NEW    = 1'b0,
    REQ_CANCEL = 1'b1
  } req_kind_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_EXEC
  } ctl_st_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  instrument;
    logic        order_side;
    logic [2:0]  response_kind;
    logic [31:0] leaves_quantity;
    logic [30:0] first_price;
    logic [30:0] second_price;
    logic [1:0]  price_valid_mask;
    logic [31:0] order_quantity;
    logic [2:0]  close_offset;
    logic [1:0]  risk_allowed_mask;
  } item_t;

  typedef struct packed {
    logic [31:0] order_id;
    logic [30:0] price;
    logic [31:0] quantity;
    logic [2:0]  offset;
  } slot_data_t;

  // one row holds the buy slot [0] and the sell slot [1] of an instrument
  typedef struct packed {
    slot_st_t   [1:0] st;
    slot_data_t [1:0] data;
  } row_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
    row_t             row;
  } mem_wr_t;

  typedef struct packed {
    req_kind_t   kind;
    logic [15:0] client;
    logic [7:0]  instrument;
    logic [31:0] order_id;
    logic        side;
    logic [30:0] price;
    logic [31:0] quantity;
    logic [2:0]  offset;
    logic        last;
  } req_t;

  typedef struct packed {
    logic                  room2;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/osm_ifs.sv
// ----------------------------------------------------------------------------
// osm interfaces
// Valid/ready channels for input items, outgoing requests and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface osm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  instrument;
  logic        order_side;
  logic [2:0]  response_kind;
  logic [31:0] leaves_quantity;
  logic [30:0] first_price;
  logic [30:0] second_price;
  logic [1:0]  price_valid_mask;
  logic [31:0] order_quantity;
  logic [2:0]  close_offset;
  logic [1:0]  risk_allowed_mask;

  modport source (
    output valid, operation, instrument, order_side, response_kind, leaves_quantity,
           first_price, second_price, price_valid_mask, order_quantity, close_offset,
           risk_allowed_mask,
    input  ready
  );
  modport sink (
    input  valid, operation, instrument, order_side, response_kind, leaves_quantity,
           first_price, second_price, price_valid_mask, order_quantity, close_offset,
           risk_allowed_mask,
    output ready
  );
endinterface

interface osm_out_if;
  logic        valid;
  logic        ready;
  logic        request_kind;
  logic [15:0] request_client;
  logic [7:0]  request_instrument;
  logic [31:0] request_order_id;
  logic        request_side;
  logic [30:0] request_price;
  logic [31:0] request_quantity;
  logic [2:0]  request_offset;
  logic        last_of_run;

  modport source (
    output valid, request_kind, request_client, request_instrument, request_order_id,
           request_side, request_price, request_quantity, request_offset, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, request_kind, request_client, request_instrument, request_order_id,
           request_side, request_price, request_quantity, request_offset, last_of_run,
    output ready
  );
endinterface

interface osm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/order_slot_state_machine.sv
// ----------------------------------------------------------------------------
// order_slot_state_machine
// Order slot per instrument and side; emits new and cancel requests.
// ----------------------------------------------------------------------------
// For every input item, in the cycle it is accepted the row of
// its instrument (buy and sell slot together) is read from the slot memories,
// and in the next cycle the row is updated, written back and up to two
// requests are queued. Because the slot row is read and then written, a new item
// is taken only once the row is written and the request queue has room for two
// more requests, so a stalled request sink stops intake once three requests are
// queued. Reset clears the row valid bits at once, so there is no clearing pass;
// the client number may be written at any time while idle.
`default_nettype none

module order_slot_state_machine (
  input  logic       clk,
  input  logic       rst_n,
  osm_in_if.sink     in_if,
  osm_out_if.source  out_if,
  osm_cfg_if.sink    cfg_if
);

  osm_pkg::ctl_st_t    ctl_r;
  osm_pkg::ctl_st_t    ctl_nxt;
  osm_pkg::item_t      item_r;
  logic                in_range_r;
  logic [15:0]         client_r;
  logic [31:0]         next_id_r;
  logic [31:0]         next_id_nxt;
  logic                in_fire;
  logic                exec_wr;
  osm_pkg::row_t       rd_row;
  osm_pkg::row_t       wr_row;
  osm_pkg::mem_wr_t    wr;
  osm_pkg::req_t       res0;
  osm_pkg::req_t       res1;
  logic [1:0]          res_n;
  logic [1:0]          push_n;
  osm_pkg::req_t       head;
  logic                head_valid;
  osm_pkg::fifo_stat_t fifo_stat;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (ctl_r == osm_pkg::CTL_IDLE) && fifo_stat.room2;
  assign in_fire      = in_if.valid && in_if.ready;
  assign exec_wr      = (ctl_r == osm_pkg::CTL_EXEC) && in_range_r;

  always_comb begin
    ctl_nxt = ctl_r;
    unique case (ctl_r)
      osm_pkg::CTL_IDLE: begin
        if (in_fire) begin
          ctl_nxt = osm_pkg::CTL_EXEC;
        end
      end
      osm_pkg::CTL_EXEC: begin
        ctl_nxt = osm_pkg::CTL_IDLE;
      end
      default: begin
        ctl_nxt = osm_pkg::CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r      <= osm_pkg::CTL_IDLE;
      in_range_r <= 1'b0;
      client_r   <= 16'd0;
      next_id_r  <= 32'd0;
    end else begin
      ctl_r <= ctl_nxt;
      if (in_fire) begin
        in_range_r <= ({1'b0, in_if.instrument} < 9'(osm_pkg::INST_COUNT));
      end
      if (cfg_if.valid && cfg_if.ready) begin
        client_r <= cfg_if.data;
      end
      if (exec_wr) begin
        next_id_r <= next_id_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.operation         <= in_if.operation;
      item_r.instrument        <= in_if.instrument;
      item_r.order_side        <= in_if.order_side;
      item_r.response_kind     <= in_if.response_kind;
      item_r.leaves_quantity   <= in_if.leaves_quantity;
      item_r.first_price       <= in_if.first_price;
      item_r.second_price      <= in_if.second_price;
      item_r.price_valid_mask  <= in_if.price_valid_mask;
      item_r.order_quantity    <= in_if.order_quantity;
      item_r.close_offset      <= in_if.close_offset;
      item_r.risk_allowed_mask <= in_if.risk_allowed_mask;
    end
  end

  always_comb begin
    wr.en   = exec_wr;
    wr.addr = item_r.instrument[osm_pkg::ROW_W-1:0];
    wr.row  = wr_row;
  end

  osm_slot_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_if.instrument[osm_pkg::ROW_W-1:0]),
    .wr      (wr),
    .rd_row  (rd_row)
  );

  osm_slot_logic u_logic (
    .item        (item_r),
    .rd_row      (rd_row),
    .client      (client_r),
    .next_id     (next_id_r),
    .wr_row      (wr_row),
    .res0        (res0),
    .res1        (res1),
    .res_n       (res_n),
    .next_id_nxt (next_id_nxt)
  );

  // out-of-range instruments leave no trace
  assign push_n = exec_wr ? res_n : 2'd0;

  osm_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .in0        (res0),
    .in1        (res1),
    .pop        (out_if.valid && out_if.ready),
    .head       (head),
    .head_valid (head_valid),
    .stat       (fifo_stat)
  );

  assign out_if.valid              = head_valid;
  assign out_if.request_kind       = head.kind;
  assign out_if.request_client     = head.client;
  assign out_if.request_instrument = head.instrument;
  assign out_if.request_order_id   = head.order_id;
  assign out_if.request_side       = head.side;
  assign out_if.request_price      = head.price;
  assign out_if.request_quantity   = head.quantity;
  assign out_if.request_offset     = head.offset;
  assign out_if.last_of_run        = head.last;

  a_exec_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == osm_pkg::CTL_EXEC) |-> fifo_stat.room2)
    else $error("request queue lacks room for an item in flight");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == osm_pkg::CTL_EXEC && !in_range_r) |-> (push_n == 2'd0 && !wr.en))
    else $error("out-of-range instrument touched state or queue");

  a_id_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == osm_pkg::CTL_IDLE) |=> (next_id_r == $past(next_id_r)))
    else $error("order id counter moved without an item");

  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    exec_wr |=> ((next_id_r - $past(next_id_r)) == 32'($past(res_n)) ||
                 (next_id_r - $past(next_id_r)) < 32'($past(res_n))))
    else $error("order id counter ran ahead of the requests queued");

  a_no_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("item accepted while a row update is pending");

endmodule

`default_nettype wire

FILE: hw/rtl/osm_slot_mem.sv
// ----------------------------------------------------------------------------
// osm_slot_mem
// Per-instrument slot rows: status and order data memories, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module osm_slot_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [osm_pkg::ROW_W-1:0] rd_addr,
  input  osm_pkg::mem_wr_t          wr,
  output osm_pkg::row_t             rd_row
);

  osm_pkg::slot_st_t   [1:0] st_mem   [osm_pkg::INST_COUNT];
  osm_pkg::slot_data_t [1:0] data_mem [osm_pkg::INST_COUNT];

  logic [osm_pkg::INST_COUNT-1:0] vld_r;
  logic                           vld_q_r;
  osm_pkg::slot_st_t   [1:0]      st_q_r;
  osm_pkg::slot_data_t [1:0]      data_q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      st_mem[wr.addr]   <= wr.row.st;
      data_mem[wr.addr] <= wr.row.data;
    end
    if (rd_en) begin
      st_q_r   <= st_mem[rd_addr];
      data_q_r <= data_mem[rd_addr];
    end
  end

  // row valid bits stand in for clearing the status memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r <= vld_r[rd_addr];
      end
    end
  end

  always_comb begin
    rd_row.data  = data_q_r;
    rd_row.st[0] = vld_q_r ? st_q_r[0] : osm_pkg::ST_INVALID;
    rd_row.st[1] = vld_q_r ? st_q_r[1] : osm_pkg::ST_INVALID;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/osm_slot_logic.sv
// ----------------------------------------------------------------------------
// osm_slot_logic
// Update of one instrument row and the requests that the item causes.
// ----------------------------------------------------------------------------
`default_nettype none

module osm_slot_logic (
  input  osm_pkg::item_t  item,
  input  osm_pkg::row_t   rd_row,
  input  logic [15:0]     client,
  input  logic [31:0]     next_id,
  output osm_pkg::row_t   wr_row,
  output osm_pkg::req_t   res0,
  output osm_pkg::req_t   res1,
  output logic [1:0]      res_n,
  output logic [31:0]     next_id_nxt
);

  typedef struct packed {
    logic                emit;
    logic                took_id;
    osm_pkg::slot_st_t   st;
    osm_pkg::slot_data_t data;
    osm_pkg::req_t       req;
  } drv_t;

  function automatic drv_t drive(
    input osm_pkg::slot_st_t   st,
    input osm_pkg::slot_data_t d,
    input logic                price_ok,
    input logic [30:0]         price,
    input logic [31:0]         qty,
    input logic [2:0]          off,
    input logic                risk_ok,
    input logic [31:0]         id,
    input logic [7:0]          inst,
    input logic                side,
    input logic [15:0]         cli
  );
    drv_t r;
    r.emit             = 1'b0;
    r.took_id          = 1'b0;
    r.st               = st;
    r.data             = d;
    r.req.kind         = osm_pkg::REQ_NEW;
    r.req.client       = cli;
    r.req.instrument   = inst;
    r.req.order_id     = id;
    r.req.side         = side;
    r.req.price        = price;
    r.req.quantity     = qty;
    r.req.offset       = off;
    r.req.last         = 1'b0;
    unique case (st)
      osm_pkg::ST_LIVE: begin
        // an invalid price always counts as a change
        if (!price_ok || d.price != price || d.quantity != qty || d.offset != off) begin
          r.emit         = 1'b1;
          r.req.kind     = osm_pkg::REQ_CANCEL;
          r.req.client   = 16'd0;
          r.req.order_id = d.order_id;
          r.req.price    = d.price;
          r.req.quantity = d.quantity;
          r.req.offset   = d.offset;
          r.st           = osm_pkg::ST_PENDING_CANCEL;
        end
      end
      osm_pkg::ST_INVALID, osm_pkg::ST_DEAD: begin
        if (price_ok && qty != 32'd0 && risk_ok) begin
          r.emit          = 1'b1;
          r.took_id       = 1'b1;
          r.data.order_id = id;
          r.data.price    = price;
          r.data.quantity = qty;
          r.data.offset   = off;
          r.st            = osm_pkg::ST_PENDING_NEW;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  drv_t        d0;
  drv_t        d1;
  logic [31:0] id1;
  logic        side;

  always_comb begin
    d0          = '0;
    d1          = '0;
    id1         = next_id;
    side        = item.order_side;
    wr_row      = rd_row;
    res0        = '0;
    res1        = '0;
    res_n       = 2'd0;
    next_id_nxt = next_id;
    unique case (item.operation)
      osm_pkg::OP_RESPONSE: begin
        unique case (item.response_kind)
          osm_pkg::RESP_ACCEPTED: begin
            wr_row.st[side] = osm_pkg::ST_LIVE;
          end
          osm_pkg::RESP_FILLED: begin
            wr_row.data[side].quantity = item.leaves_quantity;
            if (item.leaves_quantity == 32'd0) begin
              wr_row.st[side] = osm_pkg::ST_DEAD;
            end
          end
          osm_pkg::RESP_CANCELED, osm_pkg::RESP_REJECTED: begin
            wr_row.st[side] = osm_pkg::ST_DEAD;
          end
          default: begin
          end
        endcase
      end
      osm_pkg::OP_QUOTE: begin
        d0 = drive(rd_row.st[0], rd_row.data[0], item.price_valid_mask[0], item.first_price,
                   item.order_quantity, osm_pkg::OFFSET_OPEN, item.risk_allowed_mask[0],
                   next_id, item.instrument, 1'b0, client);
        id1 = next_id + {31'd0, d0.took_id};
        d1 = drive(rd_row.st[1], rd_row.data[1], item.price_valid_mask[1], item.second_price,
                   item.order_quantity, osm_pkg::OFFSET_OPEN, item.risk_allowed_mask[1],
                   id1, item.instrument, 1'b1, client);
        wr_row.st[0]   = d0.st;
        wr_row.data[0] = d0.data;
        wr_row.st[1]   = d1.st;
        wr_row.data[1] = d1.data;
        next_id_nxt    = id1 + {31'd0, d1.took_id};
        if (d0.emit) begin
          res0 = d0.req;
          res1 = d1.req;
        end else begin
          res0 = d1.req;
        end
        res_n = {1'b0, d0.emit} + {1'b0, d1.emit};
      end
      osm_pkg::OP_CLOSE: begin
        // bad offset or failed risk: no action at all, not even a cancel
        if (item.close_offset != osm_pkg::OFFSET_BAD && item.risk_allowed_mask[side]) begin
          d0 = drive(rd_row.st[side], rd_row.data[side], item.price_valid_mask[0],
                     item.first_price, item.order_quantity, item.close_offset, 1'b1,
                     next_id, item.instrument, side, client);
          wr_row.st[side]   = d0.st;
          wr_row.data[side] = d0.data;
          next_id_nxt       = next_id + {31'd0, d0.took_id};
          res0              = d0.req;
          res_n             = {1'b0, d0.emit};
        end
      end
      default: begin
      end
    endcase
    if (res_n == 2'd2) begin
      res1.last = 1'b1;
    end else if (res_n == 2'd1) begin
      res0.last = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/osm_out_fifo.sv
// ----------------------------------------------------------------------------
// osm_out_fifo
// Small request queue: takes up to two requests a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module osm_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  osm_pkg::req_t       in0,
  input  osm_pkg::req_t       in1,
  input  logic                pop,
  output osm_pkg::req_t       head,
  output logic                head_valid,
  output osm_pkg::fifo_stat_t stat
);

  osm_pkg::req_t                    mem_r [osm_pkg::FIFO_DEPTH];
  logic [osm_pkg::FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [osm_pkg::FIFO_PTR_W-1:0]   wr_ptr_nxt;
  logic [osm_pkg::FIFO_PTR_W-1:0]   wr_ptr_p1;
  logic [osm_pkg::FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [osm_pkg::FIFO_PTR_W-1:0]   rd_ptr_nxt;
  logic [osm_pkg::FIFO_CNT_W-1:0]   cnt_r;
  logic [osm_pkg::FIFO_CNT_W-1:0]   cnt_nxt;

  always_comb begin
    wr_ptr_p1  = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + osm_pkg::FIFO_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + osm_pkg::FIFO_PTR_W'(pop);
    cnt_nxt    = cnt_r + osm_pkg::FIFO_CNT_W'(push_n) - osm_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= in0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= in1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign stat.count = cnt_r;
  assign stat.room2 = (cnt_r <= osm_pkg::FIFO_CNT_W'(osm_pkg::FIFO_DEPTH - 2));

endmodule

`default_nettype wire
